// ===== rtl/core/abtr_pkg.sv =====
package abtr_pkg;

    localparam int NumRegs   = 16;
    localparam int RegIdxW   = 4;
    localparam logic [4:0] PcIdx     = 5'd15;
    localparam logic [4:0] StatusIdx = 5'd16;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_DECODE = 2'd1,
        ACT_REPLY  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_TARGET = 2'd1,
        ST_MEMRD  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        K_NONE = 3'd0,
        K_B    = 3'd1,
        K_BLX2 = 3'd2,
        K_BX   = 3'd3,
        K_LDR  = 3'd4,
        K_LDM  = 3'd5,
        K_ADD  = 3'd6,
        K_MOV  = 3'd7
    } kind_t;

    // register file read ports used by the decoder
    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] rm;
        logic [31:0] rn;
        logic [31:0] rs;
    } rf_rd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] target;
        logic        thumb;
        logic [2:0]  kind;
        logic        ldm;
        logic        user_bit;
    } dec_res_t;

    function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
        return (v >> n) | (v << (6'd32 - {1'b0, n}));
    endfunction

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [5:0] n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] imm_shift(input logic [31:0] v, input logic [1:0] ty,
                                              input logic [4:0] amt, input logic c);
        logic [31:0] r;
        case (ty)
            2'd0: r = v << amt;
            2'd1: r = (amt == 5'd0) ? 32'd0 : v >> amt;
            2'd2: r = asr32(v, (amt == 5'd0) ? 6'd32 : {1'b0, amt});
            default: r = (amt == 5'd0) ? {c, v[31:1]} : ror32(v, amt);
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/arm_branch_target_resolver.sv =====
// arm branch target resolver
// input channel (in_valid/in_ready) carries action, reg_index, data_word, opcode.
//   action write loads the register file or the carry flag (index 16, bit 29)
//   and gives no result; action decode classifies opcode and always gives one
//   result; action reply completes a pending load-multiple with one result,
//   or is dropped when nothing is pending.
// output channel (out_valid/out_ready) carries status, target, thumb, kind.
// the decode runs combinationally on register file reads and is captured in the
//   result register, so the result is valid in the cycle after the input
//   transfer.
// throughput: one item per cycle; the input is taken whenever the result
//   register is empty or being drained in the same cycle.
// when the receiver stalls, the result holds and in_ready drops until it
//   is taken.
// reset clears the carry flag, the pending load and the output valid;
// register file contents are undefined until written.
module arm_branch_target_resolver
    import abtr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [4:0]  reg_index,
    input  logic [31:0] data_word,
    input  logic [31:0] opcode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] target,
    output logic        thumb,
    output logic [2:0]  kind
);
    rf_rd_t   rd;
    logic     carry;
    dec_res_t dres;
    logic     acc;
    logic     pend_reg, pend_next, ubit_reg, ubit_next;
    logic     ov_reg, ov_next;
    logic [1:0]  st_reg, st_next;
    logic [31:0] tg_reg, tg_next;
    logic        th_reg, th_next;
    logic [2:0]  k_reg, k_next;

    assign in_ready = !ov_reg || out_ready;
    assign acc      = in_valid && in_ready;

    abtr_regfile u_rf (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (acc && action == ACT_WRITE),
        .widx  (reg_index),
        .wdata (data_word),
        .opcode(opcode),
        .rd    (rd),
        .carry (carry)
    );

    abtr_decode u_dec (
        .op    (opcode),
        .rd    (rd),
        .carry (carry),
        .res   (dres)
    );

    always_comb
    begin
        pend_next = pend_reg;
        ubit_next = ubit_reg;
        ov_next   = ov_reg && !out_ready;
        st_next   = st_reg;
        tg_next   = tg_reg;
        th_next   = th_reg;
        k_next    = k_reg;
        if (acc)
        begin
            case (action)
                ACT_DECODE:
                begin
                    ov_next   = 1'b1;
                    st_next   = dres.status;
                    tg_next   = dres.target;
                    th_next   = dres.thumb;
                    k_next    = dres.kind;
                    pend_next = dres.ldm;
                    if (dres.ldm)
                    begin
                        ubit_next = dres.user_bit;
                    end
                end
                ACT_REPLY:
                begin
                    if (pend_reg)
                    begin
                        pend_next = 1'b0;
                        ov_next   = 1'b1;
                        st_next   = ST_TARGET;
                        tg_next   = {data_word[31:1], 1'b0};
                        th_next   = ubit_reg ? 1'b0 : data_word[0];
                        k_next    = K_LDM;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            ubit_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            ubit_reg <= ubit_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        tg_reg <= tg_next;
        th_reg <= th_next;
        k_reg  <= k_next;
    end

    assign out_valid = ov_reg;
    assign status    = st_reg;
    assign target    = tg_reg;
    assign thumb     = th_reg;
    assign kind      = k_reg;

    // a decode transfer always yields a result next cycle
    a_decode_result: assert property (@(posedge clk) disable iff (!rst_n)
        acc && action == ACT_DECODE |=> out_valid)
        else $error("decode lost its result");

    // memory-read status only from a load-multiple, which leaves a load pending
    a_memrd_pending: assert property (@(posedge clk) disable iff (!rst_n)
        acc && action == ACT_DECODE && dres.status == ST_MEMRD |=> pend_reg)
        else $error("load-multiple did not arm pending load");

    // a write never produces a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        acc && action == ACT_WRITE && !(ov_reg && !out_ready) |=> !out_valid)
        else $error("write produced a result");

    // a resolved reply clears the pending load
    a_reply_clears: assert property (@(posedge clk) disable iff (!rst_n)
        acc && action == ACT_REPLY |=> !pend_reg)
        else $error("reply left load pending");
endmodule

// ===== rtl/core/abtr_regfile.sv =====
module abtr_regfile
    import abtr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        we,
    input  logic [4:0]  widx,
    input  logic [31:0] wdata,
    input  logic [31:0] opcode,
    output rf_rd_t      rd,
    output logic        carry
);
    logic [31:0] regs_reg [NumRegs];
    logic        carry_reg;

    // contents undefined until written
    always_ff @(posedge clk)
    begin
        if (we && !widx[4])
        begin
            regs_reg[widx[RegIdxW-1:0]] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= 1'b0;
        end
        else if (we && widx == StatusIdx)
        begin
            carry_reg <= wdata[29];
        end
    end

    assign rd.pc = regs_reg[PcIdx[RegIdxW-1:0]];
    assign rd.rm = regs_reg[opcode[3:0]];
    assign rd.rn = regs_reg[opcode[19:16]];
    assign rd.rs = regs_reg[opcode[11:8]];
    assign carry = carry_reg;
endmodule

// ===== rtl/core/abtr_decode.sv =====
module abtr_decode
    import abtr_pkg::*;
(
    input  logic [31:0] op,
    input  rf_rd_t      rd,
    input  logic        carry,
    output dec_res_t    res
);
    logic [31:0] boff, shop, off, base, ldra, ldma, ldr_off;
    logic [7:0]  s;
    logic [5:0]  cnt;
    logic [31:0] n4;

    always_comb
    begin
        boff = {{6{op[23]}}, op[23:0], 2'b00};

        // shifter operand
        s = rd.rs[7:0];
        if (op[25])
        begin
            shop = ror32({24'd0, op[7:0]}, {op[11:8], 1'b0});
        end
        else if (!op[4])
        begin
            shop = imm_shift(rd.rm, op[6:5], op[11:7], carry);
        end
        else if (s == 8'd0)
        begin
            shop = rd.rm;
        end
        else
        begin
            case (op[6:5])
                2'd0: shop = (s < 8'd32) ? rd.rm << s[4:0] : 32'd0;
                2'd1: shop = (s < 8'd32) ? rd.rm >> s[4:0] : 32'd0;
                2'd2: shop = asr32(rd.rm, (s < 8'd32) ? {1'b0, s[4:0]} : 6'd32);
                default: shop = ror32(rd.rm, s[4:0]);
            endcase
        end

        // ldr address
        ldr_off = (op[11:4] != 8'd0) ? imm_shift(rd.rm, op[6:5], op[11:7], carry) : rd.rm;
        off  = op[25] ? ldr_off : {20'd0, op[11:0]};
        base = rd.rn;
        ldra = !op[24] ? base : (op[23] ? base + off : base - off);

        // ldm address
        cnt = '0;
        for (int i = 0; i < 16; i++)
        begin
            cnt = cnt + 6'(op[i]);
        end
        n4 = {24'd0, cnt, 2'b00};
        ldma = op[24] ? (op[23] ? base + n4 : base - 32'd4)
                      : (op[23] ? base + n4 - 32'd4 : base);

        res = '0;
        if (op[31:28] == 4'hF)
        begin
            if ((op & 32'hFE000000) == 32'hFA000000)
            begin
                res.status = ST_TARGET;
                res.target = rd.pc + boff + {30'd0, op[24], 1'b0};
                res.thumb  = 1'b1;
                res.kind   = K_MOV;
            end
        end
        else if ((op & 32'h0E000000) == 32'h0A000000)
        begin
            res.status = ST_TARGET;
            res.target = rd.pc + boff;
            res.kind   = K_B;
        end
        else if ((op & 32'h0FFFFFF0) == 32'h012FFF30 || (op & 32'h0FFFFFF0) == 32'h012FFF10)
        begin
            res.status = ST_TARGET;
            res.target = {rd.rm[31:1], 1'b0};
            res.thumb  = rd.rm[0];
            res.kind   = op[5] ? K_BLX2 : K_BX;
        end
        else if ((op & 32'h0C50F000) == 32'h0410F000)
        begin
            res.status = ST_TARGET;
            res.target = {ldra[31:1], 1'b0};
            res.thumb  = ldra[0];
            res.kind   = K_LDR;
        end
        else if ((op & 32'h0E108000) == 32'h08108000)
        begin
            res.status   = ST_MEMRD;
            res.target   = ldma;
            res.kind     = K_LDM;
            res.ldm      = 1'b1;
            res.user_bit = op[22];
        end
        else if ((op & 32'h0DE0F000) == 32'h0080F000)
        begin
            res.status = ST_TARGET;
            res.target = rd.pc;
            res.kind   = K_ADD;
        end
        else if ((op & 32'h0DEFF000) == 32'h01A0F000)
        begin
            res.status = ST_TARGET;
            res.target = shop;
            res.kind   = K_MOV;
        end
    end
endmodule
